/* sv/bbr_pkg.sv */
// Shared types and constants for the 3x3 box blur.
package bbr_pkg;

    localparam int CHAN_W = 8;
    localparam int PIX_W  = 24;
    localparam int CFG_W  = 11;
    localparam int SUM_W  = 12;

    // Register indexes on the configuration port.
    localparam logic CFG_ACTIVE_WIDTH  = 1'b0;
    localparam logic CFG_ACTIVE_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

    // Item codes.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [CHAN_W-1:0] ALPHA_BYTE = 8'hFF;

    // x / 9 == (x * 7282) >> 16 for x below 2296.
    localparam logic [12:0] DIV9_RECIP = 13'd7282;
    localparam int          DIV9_SHIFT = 16;

    // Per-item window control, worked out in the front part.
    typedef struct packed {
        logic emit;   // a result is due on this step
        logic col0;   // left column inside the frame
        logic col2;   // right column inside the frame
        logic row0;   // upper row inside the frame
        logic row2;   // lower row inside the frame
        logic last;   // bottom-right result
    } win_ctl_t;

endpackage

/* sv/bbr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bbr_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/bbr_front.sv */
// Front part: config registers, item classification, frame position counters.
module bbr_front
    import bbr_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          op,
    input  logic [PIX_W-1:0]              pix,
    input  logic                          q_full,
    output logic                          push,
    output win_ctl_t                      push_ctl,
    output logic [$clog2(MAX_WIDTH)-1:0]  push_addr,
    output logic [PIX_W-1:0]              push_pix
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int FW = $clog2(MAX_WIDTH + 2);

    logic [CFG_W-1:0] width_reg, width_next;
    logic [CFG_W-1:0] height_reg, height_next;
    logic [XW-1:0]    ic_reg, ic_next, oc_reg, oc_next;
    logic [YW-1:0]    ir_reg, ir_next, or_reg, or_next;
    logic [FW-1:0]    fill_reg, fill_next, dcnt_reg, dcnt_next;
    logic             drain_reg, drain_next;

    logic [31:0]   w32, h32, wraw, hraw;
    logic          accept, is_flush, restart, start_drain, run, emit;
    logic [XW-1:0] c_ic, c_oc;
    logic [YW-1:0] c_ir, c_or;
    logic [FW-1:0] c_fill, dcnt_new;

    // Clamp the sizes to 1..MAX.
    always_comb
    begin
        wraw = 32'(width_reg);
        hraw = 32'(height_reg);
        if (wraw == 32'd0)
            w32 = 32'd1;
        else if (wraw > 32'(MAX_WIDTH))
            w32 = 32'(MAX_WIDTH);
        else
            w32 = wraw;
        if (hraw == 32'd0)
            h32 = 32'd1;
        else if (hraw > 32'(MAX_HEIGHT))
            h32 = 32'(MAX_HEIGHT);
        else
            h32 = hraw;
    end

    assign in_ready    = !q_full;
    assign accept      = in_valid && in_ready;
    assign is_flush    = (op == OP_FLUSH);
    assign restart     = !is_flush && drain_reg;
    assign start_drain = is_flush && !drain_reg && (fill_reg != '0)
                         && (ic_reg == '0) && (ir_reg == '0);
    assign run         = !is_flush || drain_reg || start_drain;

    // A pixel during a drain starts a fresh frame.
    assign c_ic   = restart ? '0 : ic_reg;
    assign c_ir   = restart ? '0 : ir_reg;
    assign c_oc   = restart ? '0 : oc_reg;
    assign c_or   = restart ? '0 : or_reg;
    assign c_fill = restart ? '0 : fill_reg;
    assign emit   = 32'(c_fill) >= w32 + 32'd1;

    assign push      = accept && run;
    assign push_addr = c_ic;
    assign push_pix  = is_flush ? '0 : pix;

    always_comb
    begin
        push_ctl.emit = emit;
        push_ctl.col0 = (c_oc != '0);
        push_ctl.col2 = (c_ic != '0) && (32'(c_oc) + 32'd1 < w32);
        push_ctl.row0 = (c_or != '0);
        push_ctl.row2 = (32'(c_or) + 32'd1 < h32);
        push_ctl.last = (32'(c_oc) + 32'd1 >= w32) && (32'(c_or) + 32'd1 >= h32);
    end

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        ic_next     = ic_reg;
        ir_next     = ir_reg;
        oc_next     = oc_reg;
        or_next     = or_reg;
        fill_next   = fill_reg;
        dcnt_next   = dcnt_reg;
        drain_next  = drain_reg;
        dcnt_new    = (start_drain ? '0 : dcnt_reg) + FW'(1);

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ACTIVE_WIDTH:  width_next  = cfg_data;
                CFG_ACTIVE_HEIGHT: height_next = cfg_data;
                default:           width_next  = width_reg;
            endcase
        end

        if (push)
        begin
            if (32'(c_ic) + 32'd1 >= w32)
            begin
                ic_next = '0;
                ir_next = (32'(c_ir) + 32'd1 >= h32) ? '0 : c_ir + YW'(1);
            end
            else
            begin
                ic_next = c_ic + XW'(1);
                ir_next = c_ir;
            end

            if (emit)
            begin
                fill_next = c_fill;
                if (32'(c_oc) + 32'd1 >= w32)
                begin
                    oc_next = '0;
                    or_next = (32'(c_or) + 32'd1 >= h32) ? '0 : c_or + YW'(1);
                end
                else
                begin
                    oc_next = c_oc + XW'(1);
                    or_next = c_or;
                end
            end
            else
            begin
                fill_next = c_fill + FW'(1);
                oc_next   = c_oc;
                or_next   = c_or;
            end

            drain_next = 1'b0;
            dcnt_next  = '0;
            if (is_flush)
            begin
                if (32'(dcnt_new) >= w32 + 32'd1)
                begin
                    // drain done: pipe empty
                    ic_next   = '0;
                    ir_next   = '0;
                    oc_next   = '0;
                    or_next   = '0;
                    fill_next = '0;
                end
                else
                begin
                    drain_next = 1'b1;
                    dcnt_next  = dcnt_new;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            ic_reg     <= '0;
            ir_reg     <= '0;
            oc_reg     <= '0;
            or_reg     <= '0;
            fill_reg   <= '0;
            dcnt_reg   <= '0;
            drain_reg  <= 1'b0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            ic_reg     <= ic_next;
            ir_reg     <= ir_next;
            oc_reg     <= oc_next;
            or_reg     <= or_next;
            fill_reg   <= fill_next;
            dcnt_reg   <= dcnt_next;
            drain_reg  <= drain_next;
        end
    end

endmodule

/* sv/bbr_queue.sv */
// Two-entry queue between front and back parts.
module bbr_queue #(
    parameter int WIDTH = 40
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* sv/bbr_back.sv */
// Back part: line stores, 3x3 window, channel sums and divide by nine.
module bbr_back
    import bbr_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    output logic                         q_pop,
    input  win_ctl_t                     q_ctl,
    input  logic [$clog2(MAX_WIDTH)-1:0] q_addr,
    input  logic [PIX_W-1:0]             q_pix,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [31:0]                  blurred_word,
    output logic                         last_of_frame
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int LW = 2 * PIX_W;
    localparam int PW = SUM_W + 13;

    logic en;

    // stage A: line store read in flight
    logic             a_valid_reg;
    win_ctl_t         a_ctl_reg;
    logic [XW-1:0]    a_addr_reg;
    logic [PIX_W-1:0] a_pix_reg;
    logic             byp_reg, byp_next;
    logic [LW-1:0]    byp_data_reg;
    logic [LW-1:0]    ram_rdata, line;
    logic [PIX_W-1:0] up, mid;

    // window and sums
    logic [PIX_W-1:0] taps_reg [9];
    logic [PIX_W-1:0] taps_next [9];
    logic [SUM_W-1:0] sum [3];
    logic             col_ok [3];
    logic             row_ok [3];

    // stage B: sums
    logic             b_valid_reg;
    logic             b_last_reg;
    logic [SUM_W-1:0] b_sum_reg [3];

    // stage C: output register
    logic             out_valid_reg;
    logic             out_last_reg;
    logic [31:0]      out_word_reg;
    logic [31:0]      word_next;
    logic [PW-1:0]    prod [3];

    assign en    = !out_valid_reg || out_ready;
    assign q_pop = en && q_valid;

    bbr_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .clk   (clk),
        .we    (en && a_valid_reg),
        .waddr (a_addr_reg),
        .wdata ({mid, a_pix_reg}),
        .re    (en),
        .raddr (q_addr),
        .rdata (ram_rdata)
    );

    // Same column written in the cycle it is read (e.g. one-pixel rows).
    assign line     = byp_reg ? byp_data_reg : ram_rdata;
    assign up       = line[LW-1:PIX_W];
    assign mid      = line[PIX_W-1:0];
    assign byp_next = a_valid_reg && q_valid && (q_addr == a_addr_reg);

    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            taps_next[k] = taps_reg[k + 3];
        end
        taps_next[6] = up;
        taps_next[7] = mid;
        taps_next[8] = a_pix_reg;
    end

    always_comb
    begin
        col_ok[0] = a_ctl_reg.col0;
        col_ok[1] = 1'b1;
        col_ok[2] = a_ctl_reg.col2;
        row_ok[0] = a_ctl_reg.row0;
        row_ok[1] = 1'b1;
        row_ok[2] = a_ctl_reg.row2;
        for (int ch = 0; ch < 3; ch++)
        begin
            sum[ch] = '0;
            for (int k = 0; k < 9; k++)
            begin
                if (col_ok[k / 3] && row_ok[k % 3])
                begin
                    sum[ch] = sum[ch]
                              + SUM_W'(taps_next[k][PIX_W-1-CHAN_W*ch -: CHAN_W]);
                end
            end
        end
    end

    always_comb
    begin
        word_next[CHAN_W-1:0] = ALPHA_BYTE;
        for (int ch = 0; ch < 3; ch++)
        begin
            prod[ch] = PW'(b_sum_reg[ch]) * PW'(DIV9_RECIP);
            word_next[31-CHAN_W*ch -: CHAN_W] = prod[ch][DIV9_SHIFT +: CHAN_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_ctl_reg    <= q_ctl;
            a_addr_reg   <= q_addr;
            a_pix_reg    <= q_pix;
            byp_data_reg <= {mid, a_pix_reg};
            b_last_reg   <= a_ctl_reg.last;
            b_sum_reg    <= sum;
            out_last_reg <= b_last_reg;
            out_word_reg <= word_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            byp_reg       <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 9; k++)
            begin
                taps_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            a_valid_reg   <= q_valid;
            byp_reg       <= byp_next;
            b_valid_reg   <= a_valid_reg && a_ctl_reg.emit;
            out_valid_reg <= b_valid_reg;
            if (a_valid_reg)
            begin
                taps_reg <= taps_next;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign blurred_word  = out_word_reg;
    assign last_of_frame = out_last_reg;

endmodule

/* sv/box_blur_3x3_rgb.sv */
// Top level of the streaming 3x3 RGB box blur.
// A result passes the queue and stages A, B and C after the item that
//   completes its window (one row and one pixel past the centre) is accepted.
// Throughput: one item per cycle unless stalled, set by the 1R1W line store.
// Reset (async, active low) empties queue and pipeline, zeroes the window and
//   counters and loads width 640, height 480; line stores are not cleared.
module box_blur_3x3_rgb
    import bbr_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             op,
    input  logic [31:0]      pixel_word,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [31:0]      blurred_word,
    output logic             last_of_frame
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int CW = $bits(win_ctl_t);
    localparam int QW = CW + XW + PIX_W;

    // front -> queue
    logic             push, q_full;
    win_ctl_t         push_ctl;
    logic [XW-1:0]    push_addr;
    logic [PIX_W-1:0] push_pix;

    // queue -> back
    logic             q_valid, q_pop;
    logic [QW-1:0]    q_data;
    win_ctl_t         q_ctl;
    logic [XW-1:0]    q_addr;
    logic [PIX_W-1:0] q_pix;

    // The front decides per item: pixel, drain flush or ignored flush, and
    // works out the edge masks and whether a result is due. Alpha is dropped.
    bbr_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .pix       (pixel_word[31:8]),
        .q_full    (q_full),
        .push      (push),
        .push_ctl  (push_ctl),
        .push_addr (push_addr),
        .push_pix  (push_pix)
    );

    // Short queue so each side can stall on its own.
    bbr_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  ({push_ctl, push_addr, push_pix}),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_data)
    );

    assign q_ctl  = q_data[QW-1 -: CW];
    assign q_addr = q_data[PIX_W +: XW];
    assign q_pix  = q_data[PIX_W-1:0];

    // Back: line stores, window shift, masked sums, multiply-by-reciprocal.
    bbr_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_ctl         (q_ctl),
        .q_addr        (q_addr),
        .q_pix         (q_pix),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .blurred_word  (blurred_word),
        .last_of_frame (last_of_frame)
    );

endmodule

/* sv/bbr_checker.sv */
// Port-level checks for the box blur, bound to the top level.
module bbr_checker
    import bbr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] blurred_word,
    input logic        last_of_frame
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(blurred_word)
        && $stable(last_of_frame))
        else $error("stalled result changed");

    // Alpha byte is always forced.
    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> blurred_word[7:0] == ALPHA_BYTE)
        else $error("alpha byte not forced");

    // Nothing leaves straight out of reset.
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid out of reset");

endmodule

bind box_blur_3x3_rgb bbr_checker u_chk (.*);
